>>> sv/gpce_pkg.sv
`default_nettype none
package gpce_pkg;

   localparam int OBJ_W = 5;
   localparam int VAL_W = 18;
   localparam int QCNT_W = 6;
   localparam int ENTRY_W = OBJ_W + VAL_W;

   localparam logic [1:0] CMD_POLL = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] CSR_TRIG_THR = 2'd0;
   localparam logic [1:0] CSR_LEFT_DZ  = 2'd1;
   localparam logic [1:0] CSR_RIGHT_DZ = 2'd2;

   localparam logic [7:0]  TRIG_THR_RST = 8'd30;
   localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

   localparam logic signed [VAL_W-1:0] PRESSED     = 18'sd128;
   localparam logic signed [VAL_W-1:0] AXIS_CENTER = 18'sd32768;
   localparam logic signed [VAL_W-1:0] DPAD_CENTER = -18'sd1;

   // button slots that map to a button-word bit or a trigger stop here
   localparam logic [OBJ_W-1:0] NUM_MAPPED = 5'd12;
   localparam logic [3:0] BTN_RT = 4'd6;
   localparam logic [3:0] BTN_LT = 4'd7;

   // objects after the buttons
   localparam logic [OBJ_W-1:0] OFS_LX   = 5'd0;
   localparam logic [OBJ_W-1:0] OFS_LY   = 5'd1;
   localparam logic [OBJ_W-1:0] OFS_RX   = 5'd2;
   localparam logic [OBJ_W-1:0] OFS_RY   = 5'd3;
   localparam logic [OBJ_W-1:0] OFS_DPAD = 5'd4;

   typedef struct packed {
      logic [15:0]        button_word;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
   } report_type;

   typedef struct packed {
      logic [7:0]  trigger_threshold;
      logic [14:0] left_stick_deadzone;
      logic [14:0] right_stick_deadzone;
   } cfg_type;

   function automatic logic [15:0] btn_mask(input logic [3:0] slot);
      logic [15:0] m;
      case (slot)
         4'd0:    m = 16'h1000;
         4'd1:    m = 16'h2000;
         4'd2:    m = 16'h8000;
         4'd3:    m = 16'h4000;
         4'd4:    m = 16'h0200;
         4'd5:    m = 16'h0100;
         4'd8:    m = 16'h0010;
         4'd9:    m = 16'h0020;
         4'd10:   m = 16'h0040;
         4'd11:   m = 16'h0080;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

   // bits are up, down, left, right; angle in hundredths of a degree
   function automatic logic signed [VAL_W-1:0] dpad_angle(input logic [3:0] dirs);
      logic signed [VAL_W-1:0] a;
      case (dirs)
         4'd1:    a = 18'sd0;
         4'd2:    a = 18'sd18000;
         4'd4:    a = 18'sd27000;
         4'd5:    a = 18'sd31500;
         4'd6:    a = 18'sd22500;
         4'd8:    a = 18'sd9000;
         4'd9:    a = 18'sd4500;
         4'd10:   a = 18'sd13500;
         default: a = DPAD_CENTER;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

>>> sv/gpce_ram.sv
`default_nettype none
module gpce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> sv/gpce_conv.sv
`default_nettype none
module gpce_conv
   import gpce_pkg::*;
#(
   parameter int NUM_BUTTONS = 12
) (
   input  wire report_type             report,
   input  wire cfg_type                cfg,
   input  wire logic [OBJ_W-1:0]       obj,
   output logic signed [VAL_W-1:0]     value
);

   localparam logic [OBJ_W-1:0] NB = OBJ_W'(NUM_BUTTONS);

   logic [OBJ_W-1:0]        ofs;
   logic [15:0]             mask;
   logic                    on;
   logic signed [15:0]      pos;
   logic [14:0]             dz;
   logic                    invert;
   logic signed [VAL_W-1:0] pos18;
   logic signed [VAL_W-1:0] dz18;
   logic signed [VAL_W-1:0] axis;

   always_comb begin
      ofs = obj - NB;
      case (ofs)
         OFS_LX:  begin pos = report.left_x;  dz = cfg.left_stick_deadzone;  invert = 1'b0; end
         OFS_LY:  begin pos = report.left_y;  dz = cfg.left_stick_deadzone;  invert = 1'b1; end
         OFS_RX:  begin pos = report.right_x; dz = cfg.right_stick_deadzone; invert = 1'b0; end
         default: begin pos = report.right_y; dz = cfg.right_stick_deadzone; invert = 1'b1; end
      endcase
      pos18 = {{2{pos[15]}}, pos};
      dz18 = {3'b000, dz};
      if (pos18 > dz18 || pos18 < -dz18) begin
         axis = invert ? (AXIS_CENTER - pos18) : (pos18 + AXIS_CENTER);
      end else begin
         axis = AXIS_CENTER;
      end

      mask = btn_mask(obj[3:0]);
      on = 1'b0;
      if (obj < NUM_MAPPED) begin
         if (mask != 16'h0000) begin
            on = (report.button_word & mask) != 16'h0000;
         end else if (obj[3:0] == BTN_RT) begin
            on = report.right_trigger > cfg.trigger_threshold;
         end else if (obj[3:0] == BTN_LT) begin
            on = report.left_trigger > cfg.trigger_threshold;
         end
      end

      if (obj < NB) begin
         value = on ? PRESSED : '0;
      end else begin
         case (ofs)
            OFS_LX, OFS_LY, OFS_RX, OFS_RY: value = axis;
            OFS_DPAD:                       value = dpad_angle(report.button_word[3:0]);
            default:                        value = '0;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> sv/gamepad_report_change_event_queue.sv
// Gamepad change-event queue.
// Command channel: start with req_cmd and the report fields is taken at a clock
// edge where busy is low. cmd poll converts the report into button, stick and
// d-pad values (unless changes from an earlier poll are still pending) and
// pushes every changed object that fits into the event queue; read pops the
// oldest event, peek shows it.
// Every command gives exactly one result beat on the rsp_ ports, marked by
// rsp_strobe for one cycle. The receiver cannot stall; the beat is simply
// presented once.
// A poll makes one pass over the object values, one object per cycle, through
// the single read and write port of each value memory. Read, peek and unused
// commands go through a single pop state while the registered read of the
// queue memory completes. A new command is taken in the cycle the result beat
// is shown.
// Reset clears the control state, restores the default thresholds and makes
// all object values read as zero; queue memory contents are not cleared.
// Csr writes take effect at once and are meant for idle periods.
`default_nettype none
module gamepad_report_change_event_queue
   import gpce_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32,
   parameter int NUM_BUTTONS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [15:0]              req_button_word,
   input  wire logic [7:0]               req_left_trigger,
   input  wire logic [7:0]               req_right_trigger,
   input  wire logic signed [15:0]       req_left_x,
   input  wire logic signed [15:0]       req_left_y,
   input  wire logic signed [15:0]       req_right_x,
   input  wire logic signed [15:0]       req_right_y,
   output logic                          rsp_strobe,
   output logic                          rsp_event_valid,
   output logic [OBJ_W-1:0]              rsp_event_object,
   output logic signed [VAL_W-1:0]       rsp_event_value,
   output logic [QCNT_W-1:0]             rsp_queue_count,
   input  wire logic                     csr_we,
   input  wire logic [1:0]               csr_index,
   input  wire logic [14:0]              csr_wdata
);

   localparam int NUM_OBJ = NUM_BUTTONS + 5;
   localparam int OAW = $clog2(NUM_OBJ);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = QAW + 2;
   localparam logic [OBJ_W-1:0] LAST_STEP = OBJ_W'(NUM_OBJ);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;

   logic [1:0]          state_ff, state_in;
   cfg_type             cfg_ff, cfg_in;
   report_type          report_ff;
   logic                cnv_ff;
   logic                pending_ff, pending_in;
   logic [OBJ_W-1:0]    step_ff, step_in;
   logic [NUM_OBJ-1:0]  cur_vld_ff, cur_vld_in;
   logic [NUM_OBJ-1:0]  rep_vld_ff, rep_vld_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [QAW-1:0]      head_ff, head_in;
   logic                hit_ff, pop_ff;
   logic                strobe_ff, strobe_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [OBJ_W-1:0]    ev_obj_ff, ev_obj_in;
   logic signed [VAL_W-1:0] ev_val_ff, ev_val_in;
   logic [QCNT_W-1:0]   qcnt_ff, qcnt_in;

   logic                accept;
   logic                proc_en;
   logic [OBJ_W-1:0]    obj;
   logic [OAW-1:0]      obj_addr;
   logic signed [VAL_W-1:0] conv_val;
   logic [VAL_W-1:0]    cur_q, rep_q;
   logic signed [VAL_W-1:0] cur_val, rep_val, new_val;
   logic                differ;
   logic                full;
   logic                push;
   logic                cur_we;
   logic [SW-1:0]       tail_sum;
   logic [QAW-1:0]      tail;
   logic [QAW:0]        head_inc;
   logic [ENTRY_W-1:0]  fifo_q;

   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign proc_en = state_ff == S_SCAN && step_ff != '0;
   assign obj = step_ff - 5'd1;
   assign obj_addr = obj[OAW-1:0];

   gpce_conv #(.NUM_BUTTONS(NUM_BUTTONS)) u_conv (
      .report (report_ff),
      .cfg    (cfg_ff),
      .obj    (obj),
      .value  (conv_val)
   );

   // value memories read one object ahead of the one being processed
   gpce_ram #(.WIDTH(VAL_W), .DEPTH(NUM_OBJ)) u_cur_ram (
      .clock (clock),
      .we    (cur_we),
      .waddr (obj_addr),
      .wdata (conv_val),
      .raddr (step_ff[OAW-1:0]),
      .rdata (cur_q)
   );

   gpce_ram #(.WIDTH(VAL_W), .DEPTH(NUM_OBJ)) u_rep_ram (
      .clock (clock),
      .we    (push),
      .waddr (obj_addr),
      .wdata (new_val),
      .raddr (step_ff[OAW-1:0]),
      .rdata (rep_q)
   );

   gpce_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
      .clock (clock),
      .we    (push),
      .waddr (tail),
      .wdata ({obj, new_val}),
      .raddr (head_ff),
      .rdata (fifo_q)
   );

   always_comb begin
      cur_val = cur_vld_ff[obj_addr] ? signed'(cur_q) : '0;
      rep_val = rep_vld_ff[obj_addr] ? signed'(rep_q) : '0;
      new_val = cnv_ff ? conv_val : cur_val;
      differ = new_val != rep_val;
      full = count_ff == CW'(QUEUE_DEPTH);
      push = proc_en && differ && !full;
      cur_we = proc_en && cnv_ff;

      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      end
      tail = tail_sum[QAW-1:0];
      head_inc = (QAW+1)'(head_ff) + 1'b1;
      if (head_inc == (QAW+1)'(QUEUE_DEPTH)) begin
         head_inc = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cfg_in = cfg_ff;
      pending_in = pending_ff;
      step_in = step_ff;
      cur_vld_in = cur_vld_ff;
      rep_vld_in = rep_vld_ff;
      count_in = count_ff;
      head_in = head_ff;
      strobe_in = 1'b0;
      ev_valid_in = ev_valid_ff;
      ev_obj_in = ev_obj_ff;
      ev_val_in = ev_val_ff;
      qcnt_in = qcnt_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TRIG_THR: cfg_in.trigger_threshold = csr_wdata[7:0];
            CSR_LEFT_DZ:  cfg_in.left_stick_deadzone = csr_wdata;
            CSR_RIGHT_DZ: cfg_in.right_stick_deadzone = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               step_in = '0;
               if (req_cmd == CMD_POLL) begin
                  state_in = S_SCAN;
                  pending_in = 1'b0;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_SCAN: begin
            step_in = step_ff + 5'd1;
            if (proc_en) begin
               if (cur_we) begin
                  cur_vld_in[obj_addr] = 1'b1;
               end
               if (push) begin
                  rep_vld_in[obj_addr] = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               // a change that found the queue full stays pending
               if (differ && full) begin
                  pending_in = 1'b1;
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in = S_IDLE;
               strobe_in = 1'b1;
               ev_valid_in = 1'b0;
               ev_obj_in = '0;
               ev_val_in = '0;
               qcnt_in = QCNT_W'(count_in);
            end
         end
         S_POP: begin
            state_in = S_IDLE;
            strobe_in = 1'b1;
            ev_valid_in = hit_ff;
            ev_obj_in = hit_ff ? fifo_q[ENTRY_W-1:VAL_W] : '0;
            ev_val_in = hit_ff ? signed'(fifo_q[VAL_W-1:0]) : '0;
            if (hit_ff && pop_ff) begin
               head_in = head_inc[QAW-1:0];
               count_in = count_ff - 1'b1;
            end
            qcnt_in = QCNT_W'(count_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_ff <= '{trigger_threshold: TRIG_THR_RST,
                     left_stick_deadzone: LEFT_DZ_RST,
                     right_stick_deadzone: RIGHT_DZ_RST};
         pending_ff <= 1'b0;
         step_ff <= '0;
         cur_vld_ff <= '0;
         rep_vld_ff <= '0;
         count_ff <= '0;
         head_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         pending_ff <= pending_in;
         step_ff <= step_in;
         cur_vld_ff <= cur_vld_in;
         rep_vld_ff <= rep_vld_in;
         count_ff <= count_in;
         head_ff <= head_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         report_ff <= '{button_word: req_button_word,
                        left_trigger: req_left_trigger,
                        right_trigger: req_right_trigger,
                        left_x: req_left_x,
                        left_y: req_left_y,
                        right_x: req_right_x,
                        right_y: req_right_y};
         cnv_ff <= !pending_ff;
         hit_ff <= (req_cmd == CMD_READ || req_cmd == CMD_PEEK) && count_ff != '0;
         pop_ff <= req_cmd == CMD_READ;
      end
      ev_valid_ff <= ev_valid_in;
      ev_obj_ff <= ev_obj_in;
      ev_val_ff <= ev_val_in;
      qcnt_ff <= qcnt_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_event_valid = ev_valid_ff;
   assign rsp_event_object = ev_obj_ff;
   assign rsp_event_value = ev_val_ff;
   assign rsp_queue_count = qcnt_ff;

endmodule
`default_nettype wire
